@@ sv/msm_pkg.sv @@
// Shared types, constants and the level-factor function for the sample mixer.
// No dependencies; every other file imports this package.
package msm_pkg;

	localparam int NUM_CHANNELS = 8;   // effect channels actually mixed (1..8)
	localparam int NUM_LEVELS   = 8;   // per-channel volume levels (2..8)
	localparam int PORT_CHANNELS = 8;  // channel sample fields carried on the frame
	localparam int SAMPLE_W     = 16;
	localparam int GAIN_W       = 13;
	localparam int LEVEL_W      = 3;
	localparam int MASK_W       = 8;
	localparam int LEVELS_W     = LEVEL_W * PORT_CHANNELS;
	localparam int FRAC_BITS    = 12;
	localparam int ACC_W        = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = GAIN_W;

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

	localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int FACT_W    = GAIN_W;
	// gain * (level + 1), before the divide by NUM_LEVELS
	localparam int SCALED_W  = GAIN_W + $clog2(NUM_LEVELS);
	// reciprocal of NUM_LEVELS, exact for every SCALED_W-bit dividend
	localparam int RECIP_SHIFT = SCALED_W + $clog2(NUM_LEVELS);
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + NUM_LEVELS - 1) / NUM_LEVELS;

	localparam int MUS_PROD_W  = SAMPLE_W + GAIN_W + 2;
	localparam int LANE_PROD_W = SAMPLE_W + FACT_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MUSIC_GAIN     = 2'd0,
		REG_SAMPLE_GAIN    = 2'd1,
		REG_MUSIC_ENABLE   = 2'd2,
		REG_SAMPLES_ENABLE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W:0]                         music_gain2;
		logic                                    music_en;
		logic                                    samples_en;
		logic [NUM_LEVELS-1:0][FACT_W-1:0]       factors;
	} mix_cfg_t;

	// floor(gain * mult / NUM_LEVELS) through a reciprocal multiply
	function automatic logic [FACT_W-1:0] level_factor(
		input logic [GAIN_W-1:0]    gain,
		input logic [LVL_IDX_W:0]   mult
	);
		logic [SCALED_W-1:0]         scaled;
		logic [SCALED_W+RECIP_W-1:0] prod;
		scaled = SCALED_W'(gain) * SCALED_W'(mult);
		prod   = (SCALED_W+RECIP_W)'(scaled) * (SCALED_W+RECIP_W)'(RECIP_W'(RECIP));
		return FACT_W'(prod >> RECIP_SHIFT);
	endfunction

endpackage

@@ sv/msm_in_if.sv @@
// Input frame channel: valid/ready handshake plus one mixer frame.
// Depends on msm_pkg.
interface msm_in_if
	import msm_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] music_sample;
	logic signed [SAMPLE_W-1:0] chan0_sample;
	logic signed [SAMPLE_W-1:0] chan1_sample;
	logic signed [SAMPLE_W-1:0] chan2_sample;
	logic signed [SAMPLE_W-1:0] chan3_sample;
	logic signed [SAMPLE_W-1:0] chan4_sample;
	logic signed [SAMPLE_W-1:0] chan5_sample;
	logic signed [SAMPLE_W-1:0] chan6_sample;
	logic signed [SAMPLE_W-1:0] chan7_sample;
	logic [MASK_W-1:0]          active_mask;
	logic [LEVELS_W-1:0]        channel_levels;
	logic                       frame_last;

	modport source (
		output valid, music_sample, chan0_sample, chan1_sample, chan2_sample,
		       chan3_sample, chan4_sample, chan5_sample, chan6_sample, chan7_sample,
		       active_mask, channel_levels, frame_last,
		input  ready
	);
	modport sink (
		input  valid, music_sample, chan0_sample, chan1_sample, chan2_sample,
		       chan3_sample, chan4_sample, chan5_sample, chan6_sample, chan7_sample,
		       active_mask, channel_levels, frame_last,
		output ready
	);
endinterface

@@ sv/msm_out_if.sv @@
// Output channel: valid/ready handshake plus one mixed sample.
// Depends on msm_pkg.
interface msm_out_if
	import msm_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       last_out;

	modport source (output valid, mixed_sample, last_out, input ready);
	modport sink (input valid, mixed_sample, last_out, output ready);
endinterface

@@ sv/msm_cfg.sv @@
// Configuration registers; keeps the per-level channel factors precomputed.
// Depends on msm_pkg.
module msm_cfg
	import msm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mix_cfg_t              cfg
);

	logic [GAIN_W-1:0] music_gain_q;
	logic              music_en_q;
	logic              samples_en_q;
	logic [NUM_LEVELS-1:0][FACT_W-1:0] factors_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_gain_q <= GAIN_RESET;
			music_en_q   <= 1'b0;
			samples_en_q <= 1'b1;
			for (int k = 0; k < NUM_LEVELS; k++) begin
				factors_q[k] <= level_factor(GAIN_RESET, (LVL_IDX_W+1)'(k + 1));
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MUSIC_GAIN: begin
					music_gain_q <= cfg_data[GAIN_W-1:0];
				end
				REG_SAMPLE_GAIN: begin
					// one small multiply per level, done once per write
					for (int k = 0; k < NUM_LEVELS; k++) begin
						factors_q[k] <= level_factor(cfg_data[GAIN_W-1:0],
							(LVL_IDX_W+1)'(k + 1));
					end
				end
				REG_MUSIC_ENABLE: begin
					music_en_q <= cfg_data[0];
				end
				REG_SAMPLES_ENABLE: begin
					samples_en_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.music_gain2 = {music_gain_q, 1'b0};
		cfg.music_en    = music_en_q;
		cfg.samples_en  = samples_en_q;
		cfg.factors     = factors_q;
	end

endmodule

@@ sv/msm_lane.sv @@
// One effect-channel lane: level lookup and sample-by-factor multiply.
// Depends on msm_pkg.
module msm_lane
	import msm_pkg::*;
(
	input  logic signed [SAMPLE_W-1:0]        sample,
	input  logic                              active,
	input  logic [LEVEL_W-1:0]                level,
	input  logic                              samples_en,
	input  logic [NUM_LEVELS-1:0][FACT_W-1:0] factors,
	output logic signed [ACC_W-1:0]           term
);

	logic [LEVEL_W-1:0]                lvl_eff;
	logic [FACT_W-1:0]                 factor;
	logic signed [LANE_PROD_W-1:0]     prod;

	always_comb begin
		// levels past the table saturate to the top level
		lvl_eff = level;
		if (level > LEVEL_W'(NUM_LEVELS - 1)) begin
			lvl_eff = LEVEL_W'(NUM_LEVELS - 1);
		end
		factor = factors[lvl_eff[LVL_IDX_W-1:0]];
		prod   = sample * $signed({1'b0, factor});
		term   = (active && samples_en) ? ACC_W'(prod) : '0;
	end

endmodule

@@ sv/msm_mix.sv @@
// Music scaling, 32-bit wrapping sum of all terms, Q.12 shift and int16 clamp.
// Depends on msm_pkg.
module msm_mix
	import msm_pkg::*;
(
	input  logic signed [SAMPLE_W-1:0] music_sample,
	input  logic [GAIN_W:0]            music_gain2,
	input  logic                       music_en,
	input  logic signed [ACC_W-1:0]    terms [NUM_CHANNELS],
	output logic signed [SAMPLE_W-1:0] mixed
);

	logic signed [MUS_PROD_W-1:0] music_prod;
	logic signed [ACC_W-1:0]      acc;
	logic signed [ACC_W-1:0]      shifted;
	logic                         fits;

	always_comb begin
		music_prod = music_sample * $signed({1'b0, music_gain2});
		acc = music_en ? ACC_W'(music_prod) : '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			acc = acc + terms[k];
		end
		shifted = acc >>> FRAC_BITS;
		// in range when every bit above the int16 sign matches it
		fits = (shifted[ACC_W-1:SAMPLE_W-1] == '0) || (shifted[ACC_W-1:SAMPLE_W-1] == '1);
		if (fits) begin
			mixed = shifted[SAMPLE_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			mixed = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			mixed = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

endmodule

@@ sv/multichannel_sample_mixer.sv @@
// Multichannel sample mixer: music plus effect channels into one saturated int16 sample.
// Depends on msm_pkg, msm_in_if, msm_out_if, msm_cfg, msm_lane, msm_mix.
// A frame goes from the input register through the mix into the result register.
// Throughput: one frame per cycle while results are taken; the single-pass mix sets it.
// Reset (arst_n low, asynchronous) empties both registers and loads the register defaults:
// music gain 4096, sample gain 4096, music disabled, samples enabled.
module multichannel_sample_mixer
	import msm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	msm_in_if.sink                frame,
	msm_out_if.source             result
);

	mix_cfg_t cfg;

	// input register
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] music_s1;
	logic signed [SAMPLE_W-1:0] chan_s1 [PORT_CHANNELS];
	logic [MASK_W-1:0]          mask_s1;
	logic [LEVELS_W-1:0]        levels_s1;
	logic                       last_s1;

	// result register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] mixed_q;
	logic                       last_q;

	logic                       advance;
	logic                       take;
	logic signed [ACC_W-1:0]    terms [NUM_CHANNELS];
	logic signed [SAMPLE_W-1:0] mixed;

	msm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Result register frees up when empty or when its transaction completes;
	// the input register moves on whenever the result register can take it.
	assign advance     = !out_valid_q || result.ready;
	assign frame.ready = !valid_s1 || advance;
	assign take        = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			music_s1   <= frame.music_sample;
			chan_s1[0] <= frame.chan0_sample;
			chan_s1[1] <= frame.chan1_sample;
			chan_s1[2] <= frame.chan2_sample;
			chan_s1[3] <= frame.chan3_sample;
			chan_s1[4] <= frame.chan4_sample;
			chan_s1[5] <= frame.chan5_sample;
			chan_s1[6] <= frame.chan6_sample;
			chan_s1[7] <= frame.chan7_sample;
			mask_s1    <= frame.active_mask;
			levels_s1  <= frame.channel_levels;
			last_s1    <= frame.frame_last;
		end
	end

	// one lane per mixed channel; higher channel fields are not mixed
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
		msm_lane u_lane (
			.sample     (chan_s1[i]),
			.active     (mask_s1[i]),
			.level      (levels_s1[LEVEL_W*i +: LEVEL_W]),
			.samples_en (cfg.samples_en),
			.factors    (cfg.factors),
			.term       (terms[i])
		);
	end

	msm_mix u_mix (
		.music_sample (music_s1),
		.music_gain2  (cfg.music_gain2),
		.music_en     (cfg.music_en),
		.terms        (terms),
		.mixed        (mixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			mixed_q <= mixed;
			last_q  <= last_s1;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.mixed_sample = mixed_q;
	assign result.last_out     = last_q;

	// a held result with a full input register stalls the frame side
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready && valid_s1) |-> !frame.ready)
		else $error("frame side not stalled while both registers are held");

	// a staged frame reaches the result register when it is free
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> result.valid)
		else $error("staged frame did not reach the result register");

	// a new result only ever comes from a staged frame
	a_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result valid without a staged frame");

	// with music and samples both off the mix is silent
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !cfg.music_en && !cfg.samples_en)
		|=> (result.mixed_sample == '0))
		else $error("nonzero mix with all sources disabled");

endmodule

@@ bench/msm_checker.sv @@
// Scoreboard for the sample mixer: tracks register writes, predicts every mixed sample
// from each accepted frame and compares it with the result stream.
// Depends on msm_pkg, msm_in_if and msm_out_if.
module msm_checker
	import msm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	msm_in_if                     frame,
	msm_out_if                    result,
	output int                    failures,
	output int                    pending,
	output int                    checked
);

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} mix_result_t;

	// register shadow copies
	logic [GAIN_W-1:0] mus_gain = GAIN_RESET;
	logic [GAIN_W-1:0] fx_gain  = GAIN_RESET;
	logic              mus_on   = 1'b0;
	logic              fx_on    = 1'b1;

	mix_result_t mix_expect_q[$];
	mix_result_t want;
	mix_result_t got;
	int          fail_cnt  = 0;
	int          check_cnt = 0;

	// music * 2*gain plus each active lane * floor(gain*(level+1)/levels),
	// 32-bit wrapping sum, floor shift by the fraction bits, int16 clamp
	function automatic logic [SAMPLE_W-1:0] mix_predict(
		input logic signed [SAMPLE_W-1:0]             music,
		input logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0] chans,
		input logic [MASK_W-1:0]                      mask,
		input logic [LEVELS_W-1:0]                    levels
	);
		logic signed [ACC_W-1:0] sum;
		logic signed [ACC_W-1:0] term;
		int                      lvl;
		int                      fac;
		int                      q;
		sum = '0;
		if (mus_on) begin
			term = music * (2 * int'(mus_gain));
			sum  = sum + term;
		end
		if (fx_on) begin
			for (int i = 0; i < NUM_CHANNELS && i < PORT_CHANNELS; i++) begin
				if (mask[i]) begin
					lvl = int'(levels[LEVEL_W*i +: LEVEL_W]);
					if (lvl > NUM_LEVELS - 1)
						lvl = NUM_LEVELS - 1;
					fac  = (int'(fx_gain) * (lvl + 1)) / NUM_LEVELS;
					term = $signed(chans[i]) * fac;
					sum  = sum + term;
				end
			end
		end
		q = sum >>> FRAC_BITS;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic flag_mismatch(input string field, input int want_v, input int got_v);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				field, check_cnt, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mus_gain <= GAIN_RESET;
			fx_gain  <= GAIN_RESET;
			mus_on   <= 1'b0;
			fx_on    <= 1'b1;
			mix_expect_q.delete();
			pending  <= 0;
		end else begin
			if (result.valid && result.ready) begin
				check_cnt++;
				got = '{sample: result.mixed_sample, last: result.last_out};
				if (mix_expect_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result %0d: sample %0d with no frame pending",
							check_cnt, $signed(got.sample));
				end else begin
					want = mix_expect_q.pop_front();
					if (got.sample !== want.sample)
						flag_mismatch("mixed_sample", $signed(want.sample), $signed(got.sample));
					if (got.last !== want.last)
						flag_mismatch("last_out", want.last, got.last);
				end
			end
			if (frame.valid && frame.ready)
				mix_expect_q.push_back('{
					sample: mix_predict(frame.music_sample,
						{frame.chan7_sample, frame.chan6_sample, frame.chan5_sample,
						 frame.chan4_sample, frame.chan3_sample, frame.chan2_sample,
						 frame.chan1_sample, frame.chan0_sample},
						frame.active_mask, frame.channel_levels),
					last: frame.frame_last});
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MUSIC_GAIN:     mus_gain <= cfg_data[GAIN_W-1:0];
					REG_SAMPLE_GAIN:    fx_gain  <= cfg_data[GAIN_W-1:0];
					REG_MUSIC_ENABLE:   mus_on   <= cfg_data[0];
					REG_SAMPLES_ENABLE: fx_on    <= cfg_data[0];
					default: ;
				endcase
			end
			pending  <= mix_expect_q.size();
			failures <= fail_cnt;
			checked  <= check_cnt;
		end
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the sample mixer bench: clock, reset, register writes, frame stimulus and
// result back-pressure; the verdict comes from the failure and pending counts of msm_checker.
// Depends on msm_pkg, msm_in_if, msm_out_if, msm_checker and multichannel_sample_mixer.
module tb_top;
	import msm_pkg::*;

	// Watchdog cycle limit, chosen well above the length of the slowest legal run.
	localparam int CYCLE_LIMIT = 200000;
	// Long output hold-off used to fill the pipeline and back up the frame channel.
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [SAMPLE_W-1:0]                     music;
		logic [PORT_CHANNELS-1:0][SAMPLE_W-1:0]  chans;
		logic [MASK_W-1:0]                       mask;
		logic [LEVELS_W-1:0]                     levels;
		logic                                    last;
	} mix_frame_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  hold_ask;

	int failures;
	int pending;
	int checked;
	int frames_sent = 0;
	int cfg_phases  = 0;
	int cycle_cnt   = 0;

	msm_in_if  frame_ch();
	msm_out_if result_ch();

	multichannel_sample_mixer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame_ch),
		.result    (result_ch)
	);

	msm_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame_ch),
		.result    (result_ch),
		.failures  (failures),
		.pending   (pending),
		.checked   (checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_cnt, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver side. Ready follows stall modes of random length (always ready, light,
	// medium and heavy stalling). On a one-cycle request pulse it holds off for
	// HOLD_CYCLES so the mixer fills up and drops frame ready while the sender keeps offering.
	initial begin : drain_side
		int mode_left;
		int stall_pct;
		result_ch.ready <= 1'b0;
		mode_left = 0;
		stall_pct = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 4))
						0, 1:    stall_pct = 0;
						2:       stall_pct = 30;
						3:       stall_pct = 60;
						default: stall_pct = 90;
					endcase
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Put one frame on the channel and hold it until the transaction completes.
	// Valid stays high on return so back-to-back frames need no extra edge.
	task automatic offer_frame(input mix_frame_t f);
		frame_ch.valid          <= 1'b1;
		frame_ch.music_sample   <= f.music;
		frame_ch.chan0_sample   <= f.chans[0];
		frame_ch.chan1_sample   <= f.chans[1];
		frame_ch.chan2_sample   <= f.chans[2];
		frame_ch.chan3_sample   <= f.chans[3];
		frame_ch.chan4_sample   <= f.chans[4];
		frame_ch.chan5_sample   <= f.chans[5];
		frame_ch.chan6_sample   <= f.chans[6];
		frame_ch.chan7_sample   <= f.chans[7];
		frame_ch.active_mask    <= f.mask;
		frame_ch.channel_levels <= f.levels;
		frame_ch.frame_last     <= f.last;
		do @(posedge clk); while (!frame_ch.ready);
		frames_sent++;
	endtask

	// Stop offering and wait for the scoreboard to run empty. The first edge is
	// always taken so the count reflects the last transaction.
	task automatic wait_results();
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	// All four registers in consecutive cycles, write enable held high throughout.
	// Enable writes carry random upper bits; only bit 0 counts.
	task automatic set_config(input int mg, input int sg, input bit me, input bit se);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MUSIC_GAIN;
		cfg_data  <= CFG_DATA_W'(mg);
		@(posedge clk);
		cfg_index <= REG_SAMPLE_GAIN;
		cfg_data  <= CFG_DATA_W'(sg);
		@(posedge clk);
		cfg_index <= REG_MUSIC_ENABLE;
		cfg_data  <= {(CFG_DATA_W-1)'($urandom), me};
		@(posedge clk);
		cfg_index <= REG_SAMPLES_ENABLE;
		cfg_data  <= {(CFG_DATA_W-1)'($urandom), se};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_phases++;
	endtask

	// Random frame content with a few shapes mixed in: full-scale same-sign frames
	// that drive the sum into the clamp (and into wrap at high gains), near-zero
	// frames that exercise floor rounding of small negatives, and all-active frames.
	function automatic mix_frame_t random_frame();
		mix_frame_t f;
		int         style;
		bit         neg;
		f.music = SAMPLE_W'($urandom);
		for (int i = 0; i < PORT_CHANNELS; i++)
			f.chans[i] = SAMPLE_W'($urandom);
		f.mask   = MASK_W'($urandom);
		f.levels = LEVELS_W'($urandom);
		f.last   = 1'($urandom_range(0, 1));
		style    = $urandom_range(0, 9);
		neg      = 1'($urandom_range(0, 1));
		case (style)
			0, 1: begin
				f.music = neg ? SAMPLE_W'(16'h8000 + $urandom_range(0, 255))
				              : SAMPLE_W'(16'h7FFF - $urandom_range(0, 255));
				for (int i = 0; i < PORT_CHANNELS; i++)
					f.chans[i] = neg ? SAMPLE_W'(16'h8000 + $urandom_range(0, 255))
					                 : SAMPLE_W'(16'h7FFF - $urandom_range(0, 255));
				if (style == 0)
					f.mask = '1;
			end
			2: begin
				f.music = SAMPLE_W'($urandom_range(0, 31) - 16);
				for (int i = 0; i < PORT_CHANNELS; i++)
					f.chans[i] = SAMPLE_W'($urandom_range(0, 31) - 16);
			end
			3: f.mask = '1;
			default: ;
		endcase
		return f;
	endfunction

	// Random frames in bursts of random length with idle gaps between them.
	task automatic send_random(input int count);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 24);
		for (int k = 0; k < count; k++) begin
			offer_frame(random_frame());
			burst_left--;
			if (burst_left == 0 && k != count - 1) begin
				gap = $urandom_range(1, 8);
				frame_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Hand-picked frames, run with music and samples both on at unity gain.
	task automatic run_directed();
		mix_frame_t f;
		// silence
		f = '0;
		offer_frame(f);
		// everything at positive full scale, top level: clamps high
		f.music  = 16'h7FFF;
		f.chans  = {PORT_CHANNELS{16'h7FFF}};
		f.mask   = '1;
		f.levels = '1;
		f.last   = 1'b1;
		offer_frame(f);
		// everything at negative full scale: clamps low
		f.music = 16'h8000;
		f.chans = {PORT_CHANNELS{16'h8000}};
		f.last  = 1'b0;
		offer_frame(f);
		// music alone at both extremes and just under the clamp
		f = '0;
		f.music = 16'h8000;
		offer_frame(f);
		f.music = 16'h7FFF;
		offer_frame(f);
		f.music = 16'h3FFF;
		offer_frame(f);
		// each lane alone, lane i at level i
		for (int i = 0; i < PORT_CHANNELS; i++) begin
			f = '0;
			f.chans[i] = 16'h7FFF;
			f.mask     = MASK_W'(1 << i);
			f.levels   = LEVELS_W'(i) << (LEVEL_W * i);
			f.last     = 1'(i);
			offer_frame(f);
		end
		// minus one in every lane at the lowest level: floor goes to -1, not 0
		f = '0;
		f.chans = {PORT_CHANNELS{16'hFFFF}};
		f.mask  = '1;
		offer_frame(f);
		// plus one everywhere at the top level: eight full-gain ones sum to exactly 8
		f.chans  = {PORT_CHANNELS{16'h0001}};
		f.levels = '1;
		offer_frame(f);
		// loud lanes with no active bit contribute nothing
		f       = '0;
		f.chans = {PORT_CHANNELS{16'h7FFF}};
		f.levels = '1;
		f.last  = 1'b1;
		offer_frame(f);
		// sparse mask with mixed levels and random content
		f        = random_frame();
		f.mask   = 8'hA5;
		f.levels = 24'hFAC688;
		offer_frame(f);
	endtask

	initial begin : stimulus
		// every DUT input known from time zero
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= REG_MUSIC_GAIN;
		cfg_data                <= '0;
		hold_ask                <= 1'b0;
		frame_ch.valid          <= 1'b0;
		frame_ch.music_sample   <= '0;
		frame_ch.chan0_sample   <= '0;
		frame_ch.chan1_sample   <= '0;
		frame_ch.chan2_sample   <= '0;
		frame_ch.chan3_sample   <= '0;
		frame_ch.chan4_sample   <= '0;
		frame_ch.chan5_sample   <= '0;
		frame_ch.chan6_sample   <= '0;
		frame_ch.chan7_sample   <= '0;
		frame_ch.active_mask    <= '0;
		frame_ch.channel_levels <= '0;
		frame_ch.frame_last     <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: music off, samples on at unity
		send_random(20);
		wait_results();

		set_config(4096, 4096, 1'b1, 1'b1);
		run_directed();
		wait_results();

		// zero gains
		set_config(0, 0, 1'b1, 1'b1);
		send_random(40);
		wait_results();

		// largest gain words: the accumulator wraps on loud frames
		set_config(8191, 8191, 1'b1, 1'b1);
		send_random(40);
		wait_results();

		// both sources off: output must be zero
		set_config(4096, 4096, 1'b0, 1'b0);
		send_random(20);
		wait_results();

		// music only
		set_config(2048, 8191, 1'b1, 1'b0);
		send_random(30);
		wait_results();

		// random settings, mostly in the nominal gain range
		for (int p = 0; p < 6; p++) begin
			set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
			                                       : $urandom_range(0, 4096),
			           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
			                                       : $urandom_range(0, 4096),
			           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			// one phase runs under a long output stall to back up the frame channel
			if (p == 2) begin
				hold_ask <= 1'b1;
				@(posedge clk);
				hold_ask <= 1'b0;
			end
			send_random(40);
			wait_results();
		end

		repeat (8) @(posedge clk);
		$display("ran %0d frames across %0d register settings, %0d results checked",
			frames_sent, cfg_phases, checked);
		$display("covered clamp and wrap, lane/level sweep, source enables, long output stall");
		if (failures == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
sv/msm_pkg.sv
sv/msm_in_if.sv
sv/msm_out_if.sv
sv/msm_cfg.sv
sv/msm_lane.sv
sv/msm_mix.sv
sv/multichannel_sample_mixer.sv
bench/msm_checker.sv
bench/tb_top.sv
